### sv/ccfr_pkg.sv
// Shared constants, types and the CRC-32C byte step for the frame receiver.
package ccfr_pkg;

  localparam int unsigned PtrW      = 6;
  localparam int unsigned RamDepth  = 64;
  localparam int unsigned BodyBits  = 224;

  localparam logic [PtrW-1:0] FrameBytes = 6'd36;
  localparam logic [PtrW-1:0] CrcSpan    = 6'd32;
  localparam logic [PtrW-1:0] KindPos    = 6'd3;
  localparam logic [PtrW-1:0] BodyFirst  = 6'd4;
  localparam logic [PtrW-1:0] ZeroFirst  = 6'd16;
  localparam logic [PtrW-1:0] LastPos    = 6'd35;

  localparam logic [7:0] HdrSync0   = 8'h41;  // 'A'
  localparam logic [7:0] HdrSync1   = 8'h4D;  // 'M'
  localparam logic [7:0] HdrVersion = 8'h01;

  localparam logic [15:0] GapTimeoutReset = 16'd100;

  localparam logic [31:0] CrcPoly = 32'h82F63B78;
  localparam logic [31:0] CrcInit = 32'hFFFFFFFF;

  typedef enum logic [1:0] {
    VerdictLocal   = 2'd0,
    VerdictForward = 2'd1,
    VerdictReject  = 2'd2
  } verdict_e;

  typedef struct packed {
    logic clr;  // load the initial value
    logic en;   // fold in one byte
  } crc_ctrl_t;

  // Reflected CRC-32C, one byte folded in LSB first.
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### sv/ccfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ccfr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/ccfr_crc.sv
// CRC-32C accumulator, one byte per cycle while en is set.
module ccfr_crc (
  input  logic                  clk_i,
  input  ccfr_pkg::crc_ctrl_t   ctrl_i,
  input  logic [7:0]            byte_i,
  output logic [31:0]           crc_o
);

  logic [31:0] crc_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr) begin
      crc_q <= ccfr_pkg::CrcInit;
    end else if (ctrl_i.en) begin
      crc_q <= ccfr_pkg::crc32c_byte(crc_q, byte_i);
    end
  end

  // final inversion
  assign crc_o = crc_q ^ ccfr_pkg::CrcInit;

endmodule

### sv/crc_checked_frame_receiver.sv
// Top level of the CRC-checked 36-byte frame receiver.
// Bytes arrive one item at a time with a millisecond timestamp and are held in a
// 64-entry circular byte RAM (head pointer plus fill count, so dropping the first
// byte is a pointer bump, not a shift). A frame is 'A', 'M', 0x01, a kind byte, 28
// body bytes and a little-endian CRC-32C of bytes 0..31 in bytes 32..35. A gap of at
// least gap_timeout_ms between bytes drops a partial frame; bytes that break the
// header are dropped one at a time; a CRC mismatch drops the first byte and the
// remaining 35 are rechecked when the next byte comes in. Each good frame yields one
// result item: kind, seven body words, verdict and the saturating reject total.
// Sequence: a byte is accepted, then the header is checked by a read step and a
// compare step for each of up to 3 header bytes, restarting after each dropped byte,
// then a closing step. A byte that completes 36 held bytes adds a wait step, a scan
// streaming the frame through the RAM read port into the CRC byte unit, and a judge
// step. No new byte is accepted until this work is done. The single RAM read port
// paces the scan. If a previous result has not yet been taken
// when a full frame is ready, the frame scan waits for it and the input stays
// stalled meanwhile; bytes that do not complete a frame are accepted while a result
// waits. in_stall_o is high while an item is being worked on. The RAM needs no
// clearing; only bytes below the fill count are ever read.
module crc_checked_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic [31:0] now_ms_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  frame_kind_o,
  output logic [1:0]  verdict_o,
  output logic [31:0] body_word_0_o,
  output logic [31:0] body_word_1_o,
  output logic [31:0] body_word_2_o,
  output logic [31:0] body_word_3_o,
  output logic [31:0] body_word_4_o,
  output logic [31:0] body_word_5_o,
  output logic [31:0] body_word_6_o,
  output logic [31:0] reject_total_o,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] gap_timeout_ms_i
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StHdrRd  = 3'd1;
  localparam logic [2:0] StHdrChk = 3'd2;
  localparam logic [2:0] StWait   = 3'd3;
  localparam logic [2:0] StScan   = 3'd4;
  localparam logic [2:0] StFin    = 3'd5;

  localparam logic [1:0] HdrLen = 2'd3;

  logic [2:0]  state_q, state_d;
  logic [5:0]  head_q, head_d;      // circular RAM position of byte 0
  logic [5:0]  fill_q, fill_d;      // bytes held, 0..36
  logic [1:0]  hidx_q, hidx_d;      // header byte under check
  logic [5:0]  iss_q, iss_d;        // next frame position to read
  logic [5:0]  cidx_q, cidx_d;      // frame position of the read data
  logic        cvld_q, cvld_d;
  logic [31:0] last_time_q, last_time_d;
  logic [31:0] reject_q, reject_d;
  logic [15:0] timeout_q;

  logic [7:0]  kind_q, kind_d;
  logic [ccfr_pkg::BodyBits-1:0] body_q, body_d;
  logic [31:0] crc_field_q, crc_field_d;
  logic        tail_nz_q, tail_nz_d;   // some byte of 16..31 nonzero
  logic [1:0]  verdict_q, verdict_d;
  logic [31:0] reject_total_q, reject_total_d;
  logic        out_valid_q, out_valid_d;

  logic        in_acc;
  logic [31:0] elapsed;
  logic        gap_drop;
  logic [5:0]  fill_base;
  logic        ram_we;
  logic [5:0]  ram_waddr;
  logic        ram_re;
  logic [5:0]  ram_raddr;
  logic [7:0]  ram_rdata;
  logic        rej_inc;
  logic [31:0] reject_inc;
  logic [7:0]  hdr_expect;
  logic [31:0] crc_calc;
  ccfr_pkg::crc_ctrl_t crc_ctrl;
  ccfr_pkg::verdict_e  verdict_calc;

  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // wrapping elapsed time since the previous byte
  assign elapsed   = now_ms_i - last_time_q;
  assign gap_drop  = (fill_q != 6'd0) && (elapsed >= {16'd0, timeout_q});
  assign fill_base = gap_drop ? 6'd0 : fill_q;

  assign ram_we    = in_acc;
  assign ram_waddr = head_q + fill_base;

  assign reject_inc = (reject_q == 32'hFFFFFFFF) ? reject_q : reject_q + 32'd1;

  always_comb begin
    case (hidx_q)
      2'd0:    hdr_expect = ccfr_pkg::HdrSync0;
      2'd1:    hdr_expect = ccfr_pkg::HdrSync1;
      default: hdr_expect = ccfr_pkg::HdrVersion;
    endcase
  end

  always_comb begin
    if ((kind_q inside {[8'd4:8'd6]}) && (body_q[31:0] != 32'd0)) begin
      verdict_calc = tail_nz_q ? ccfr_pkg::VerdictReject : ccfr_pkg::VerdictLocal;
    end else if (kind_q inside {[8'd1:8'd3]}) begin
      verdict_calc = ccfr_pkg::VerdictForward;
    end else begin
      verdict_calc = ccfr_pkg::VerdictReject;
    end
  end

  always_comb begin
    state_d        = state_q;
    head_d         = head_q;
    fill_d         = fill_q;
    hidx_d         = hidx_q;
    iss_d          = iss_q;
    cidx_d         = cidx_q;
    cvld_d         = 1'b0;
    last_time_d    = last_time_q;
    kind_d         = kind_q;
    body_d         = body_q;
    crc_field_d    = crc_field_q;
    tail_nz_d      = tail_nz_q;
    verdict_d      = verdict_q;
    reject_total_d = reject_total_q;
    out_valid_d    = out_valid_q && out_stall_i;
    rej_inc        = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = head_q;
    crc_ctrl       = '0;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          rej_inc     = gap_drop;
          last_time_d = now_ms_i;
          fill_d      = fill_base + 6'd1;
          hidx_d      = 2'd0;
          state_d     = StHdrRd;
        end
      end
      StHdrRd: begin
        if (({4'd0, hidx_q} >= fill_q) || (hidx_q == HdrLen)) begin
          state_d = (fill_q == ccfr_pkg::FrameBytes) ? StWait : StIdle;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = head_q + {4'd0, hidx_q};
          state_d   = StHdrChk;
        end
      end
      StHdrChk: begin
        if (ram_rdata != hdr_expect) begin
          // drop the first byte, restart the header check
          head_d  = head_q + 6'd1;
          fill_d  = fill_q - 6'd1;
          rej_inc = 1'b1;
          hidx_d  = 2'd0;
        end else begin
          hidx_d = hidx_q + 2'd1;
        end
        state_d = StHdrRd;
      end
      StWait: begin
        // frame scan reuses the result registers
        if (!out_valid_q) begin
          crc_ctrl.clr = 1'b1;
          tail_nz_d    = 1'b0;
          iss_d        = 6'd0;
          state_d      = StScan;
        end
      end
      StScan: begin
        if (iss_q != ccfr_pkg::FrameBytes) begin
          ram_re    = 1'b1;
          ram_raddr = head_q + iss_q;
          iss_d     = iss_q + 6'd1;
          cidx_d    = iss_q;
          cvld_d    = 1'b1;
        end
        if (cvld_q) begin
          if (cidx_q < ccfr_pkg::CrcSpan) begin
            crc_ctrl.en = 1'b1;
          end else begin
            crc_field_d = {ram_rdata, crc_field_q[31:8]};
          end
          if (cidx_q == ccfr_pkg::KindPos) begin
            kind_d = ram_rdata;
          end
          if ((cidx_q >= ccfr_pkg::BodyFirst) && (cidx_q < ccfr_pkg::CrcSpan)) begin
            body_d = {ram_rdata, body_q[ccfr_pkg::BodyBits-1:8]};
          end
          if ((cidx_q >= ccfr_pkg::ZeroFirst) && (cidx_q < ccfr_pkg::CrcSpan) &&
              (ram_rdata != 8'd0)) begin
            tail_nz_d = 1'b1;
          end
          if (cidx_q == ccfr_pkg::LastPos) begin
            state_d = StFin;
          end
        end
      end
      StFin: begin
        if (crc_field_q != crc_calc) begin
          // resync: drop the first byte, header rechecked on the next byte
          head_d  = head_q + 6'd1;
          fill_d  = fill_q - 6'd1;
          rej_inc = 1'b1;
        end else begin
          rej_inc        = (verdict_calc == ccfr_pkg::VerdictReject);
          verdict_d      = verdict_calc;
          reject_total_d = rej_inc ? reject_inc : reject_q;
          out_valid_d    = 1'b1;
          fill_d         = 6'd0;
        end
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    reject_d = rej_inc ? reject_inc : reject_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      head_q      <= 6'd0;
      fill_q      <= 6'd0;
      hidx_q      <= 2'd0;
      iss_q       <= 6'd0;
      cidx_q      <= 6'd0;
      cvld_q      <= 1'b0;
      last_time_q <= 32'd0;
      reject_q    <= 32'd0;
      timeout_q   <= ccfr_pkg::GapTimeoutReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      hidx_q      <= hidx_d;
      iss_q       <= iss_d;
      cidx_q      <= cidx_d;
      cvld_q      <= cvld_d;
      last_time_q <= last_time_d;
      reject_q    <= reject_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        timeout_q <= gap_timeout_ms_i;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    kind_q         <= kind_d;
    body_q         <= body_d;
    crc_field_q    <= crc_field_d;
    tail_nz_q      <= tail_nz_d;
    verdict_q      <= verdict_d;
    reject_total_q <= reject_total_d;
  end

  ccfr_ram #(
    .Width(8),
    .Depth(ccfr_pkg::RamDepth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(rx_byte_i),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  ccfr_crc u_crc (
    .clk_i (clk_i),
    .ctrl_i(crc_ctrl),
    .byte_i(ram_rdata),
    .crc_o (crc_calc)
  );

  assign out_valid_o    = out_valid_q;
  assign frame_kind_o   = kind_q;
  assign verdict_o      = verdict_q;
  assign body_word_0_o  = body_q[31:0];
  assign body_word_1_o  = body_q[63:32];
  assign body_word_2_o  = body_q[95:64];
  assign body_word_3_o  = body_q[127:96];
  assign body_word_4_o  = body_q[159:128];
  assign body_word_5_o  = body_q[191:160];
  assign body_word_6_o  = body_q[223:192];
  assign reject_total_o = reject_total_q;

  // never more than one frame held
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= ccfr_pkg::FrameBytes)
    else $error("fill count beyond frame size");

  // a result only appears after a frame was judged
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == StFin)
    else $error("result raised outside the judge step");

  // scanning only runs over a full frame with the output free
  a_scan_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (fill_q == ccfr_pkg::FrameBytes) && !out_valid_q)
    else $error("frame scan without a full frame or with a pending result");

endmodule
